/* sv/sorted_timer_expiry_queue_defines.svh */
// ----------------------------------------------------------------------------
// Sorted timer expiry queue: assertion macros
// Shared property shapes, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EXPIRY_QUEUE_DEFINES_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_DEFINES_SVH

// Same-cycle implication
`define STQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define STQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/stq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Widths, constants, list entry type and the controller/datapath interface
// of the sorted timer expiry queue.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int SLOT_W    = 4;
	localparam int DL_W      = 32;
	localparam int Q_W       = 4;
	localparam int BYTE_W    = 8;
	localparam int NUM_SLOTS = 16;

	localparam logic [DL_W-1:0] NO_DEADLINE = 32'hffff_ffff;

	// One list entry: timer slot and its absolute deadline
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [DL_W-1:0]   dl;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_EXP_CUR,
		ST_EXP_NXT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic cap;        // capture input transfer, bump tick count on a tick
		logic ins_start;  // claim slot, start tail walk
		logic ins_shift;  // move one entry up, step walk down
		logic ins_put;    // write new entry, grow list
		logic exp_read;   // read list head
		logic exp_pop;    // take head as current expiry, advance head
		logic emit;       // load output register from current expiry
		logic exp_done;   // reload next deadline
	} stq_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_set;     // captured item starts a timer
		logic due;        // next deadline reached
		logic cnt_zero;   // list empty
		logic ins_ok;     // slot idle and list not full
		logic rem_one;    // walk is at the list head
		logic shift;      // walked entry lies after the new one
		logic more;       // next head also expires
		logic out_free;   // output register can take a result
	} stq_status_t;

endpackage

/* sv/sorted_timer_expiry_queue.sv */
`timescale 1ns / 1ps
// Takes one item at a time: in_stall is high from the transfer until the item
// is finished. A tick that expires timers gives one result per cycle while
// the output is not stalled. A timer start walks down the list memory past
// each entry with a later deadline, with one read and one write per cycle. A
// start for a running slot or into a full list is ignored. Results wait in an
// output register, so the next item is taken while the last result of a tick
// is still stalled. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue
// Tick counter with a deadline-sorted timer list; emits every timer that
// expires on a tick, in deadline order, and inserts started timers in order.
// ----------------------------------------------------------------------------
`include "sorted_timer_expiry_queue_defines.svh"

module sorted_timer_expiry_queue #(
	parameter int MAX_TIMERS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [stq_pkg::SLOT_W-1:0] timer_id,
	input  logic [stq_pkg::DL_W-1:0]   deadline,
	input  logic [stq_pkg::Q_W-1:0]    dest_queue,
	input  logic [stq_pkg::BYTE_W-1:0] payload,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [stq_pkg::SLOT_W-1:0] expired_id,
	output logic [stq_pkg::Q_W-1:0]    out_queue,
	output logic [stq_pkg::BYTE_W-1:0] out_byte,
	output logic                       last
);
	import stq_pkg::*;

	localparam int CW = $clog2(MAX_TIMERS + 1);

	stq_cmd_t             cmd;
	stq_status_t          st;
	logic [CW-1:0]        active;
	logic [NUM_SLOTS-1:0] run_mask;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	stq_dp #(
		.MAX_TIMERS (MAX_TIMERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode),
		.timer_id     (timer_id),
		.deadline     (deadline),
		.dest_queue   (dest_queue),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.expired_id   (expired_id),
		.out_queue    (out_queue),
		.out_byte     (out_byte),
		.last         (last),
		.cmd          (cmd),
		.st           (st),
		.active_count (active),
		.running      (run_mask)
	);

	// Checks
	`STQ_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "idle right after a transfer")
	`STQ_ASSERT_IMP(a_emit_free, cmd.emit, !(out_valid && out_stall), "result overwrote a stalled one")
	`STQ_ASSERT_IMP(a_count_match, !in_stall, CW'($countones(run_mask)) == active, "list size and running slots differ")
	`STQ_ASSERT_NXT(a_last_idle, cmd.emit && !st.more, !in_stall, "still busy after final expiry")

endmodule

/* sv/stq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the timer queue: dispatches ticks and timer starts, walks
// the list on insert and pops expired heads one result at a time.
// ----------------------------------------------------------------------------
module stq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  stq_pkg::stq_status_t st,
	output stq_pkg::stq_cmd_t    cmd
);
	import stq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap   = 1'b1;
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (st.is_set) begin
					if (st.ins_ok) begin
						cmd.ins_start = 1'b1;
						state_nxt     = st.cnt_zero ? ST_INS_PUT : ST_INS_CMP;
					end else begin
						state_nxt = ST_IDLE;
					end
				end else if (st.due && !st.cnt_zero) begin
					cmd.exp_read = 1'b1;
					state_nxt    = ST_EXP_CUR;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_INS_CMP: begin
				if (st.shift) begin
					cmd.ins_shift = 1'b1;
					if (st.rem_one) begin
						state_nxt = ST_INS_PUT;
					end
				end else begin
					cmd.ins_put = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			ST_INS_PUT: begin
				cmd.ins_put = 1'b1;
				state_nxt   = ST_IDLE;
			end
			ST_EXP_CUR: begin
				cmd.exp_pop = 1'b1;
				state_nxt   = ST_EXP_NXT;
			end
			ST_EXP_NXT: begin
				// hold current expiry until the output register frees up
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.more) begin
						cmd.exp_pop = 1'b1;
					end else begin
						cmd.exp_done = 1'b1;
						state_nxt    = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/stq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_dp
// Datapath of the timer queue: tick counter, next deadline, circular sorted
// list in a single-port-write memory, per-slot targets and running bits,
// and the output register.
// ----------------------------------------------------------------------------
module stq_dp #(
	parameter int MAX_TIMERS = 16,
	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1,
	localparam int CW = $clog2(MAX_TIMERS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mode,
	input  logic [stq_pkg::SLOT_W-1:0]    timer_id,
	input  logic [stq_pkg::DL_W-1:0]      deadline,
	input  logic [stq_pkg::Q_W-1:0]       dest_queue,
	input  logic [stq_pkg::BYTE_W-1:0]    payload,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [stq_pkg::SLOT_W-1:0]    expired_id,
	output logic [stq_pkg::Q_W-1:0]       out_queue,
	output logic [stq_pkg::BYTE_W-1:0]    out_byte,
	output logic                          last,
	input  stq_pkg::stq_cmd_t             cmd,
	output stq_pkg::stq_status_t          st,
	output logic [CW-1:0]                 active_count,
	output logic [stq_pkg::NUM_SLOTS-1:0] running
);
	import stq_pkg::*;

	localparam logic [IW:0] DEPTH = (IW + 1)'(MAX_TIMERS);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
		return (x == IW'(MAX_TIMERS - 1)) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] x);
		return (x == '0) ? IW'(MAX_TIMERS - 1) : x - 1'b1;
	endfunction

	// Captured input item
	logic                  mode_q;
	logic [SLOT_W-1:0]     id_q;
	logic [DL_W-1:0]       dl_q;
	logic [Q_W-1:0]        queue_q;
	logic [BYTE_W-1:0]     byte_q;

	// Control state
	logic [DL_W-1:0]       tick_q;
	logic [DL_W-1:0]       next_dl_q;
	logic [CW-1:0]         cnt_q;
	logic [IW-1:0]         head_q;
	logic [IW-1:0]         ptr_q;
	logic [CW-1:0]         rem_q;
	logic [NUM_SLOTS-1:0]  running_q;
	logic                  out_valid_q;

	// List memory and slot table
	entry_t                list_q [MAX_TIMERS];
	entry_t                rd_q;
	logic [Q_W+BYTE_W-1:0] target_q [NUM_SLOTS];
	logic [SLOT_W-1:0]     cur_q;

	// Output register
	logic [SLOT_W-1:0]     exp_id_q;
	logic [Q_W-1:0]        oq_q;
	logic [BYTE_W-1:0]     ob_q;
	logic                  last_q;

	logic [IW:0]           tail_sum;
	logic [IW:0]           tail_wrap;
	logic [IW-1:0]         tail;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	entry_t                wr_data;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;

	// Tail index: head + count - 1, modulo the list depth
	always_comb begin
		tail_sum  = {1'b0, head_q} + (IW + 1)'(cnt_q);
		tail_wrap = (tail_sum >= DEPTH) ? tail_sum - DEPTH : tail_sum;
		tail      = wrap_dec(tail_wrap[IW-1:0]);
	end

	// Memory port select
	assign wr_en   = cmd.ins_shift | cmd.ins_put;
	assign wr_addr = wrap_inc(ptr_q);
	assign wr_data = cmd.ins_put ? entry_t'{slot: id_q, dl: dl_q} : rd_q;
	assign rd_en   = cmd.ins_start | cmd.ins_shift | cmd.exp_read | cmd.exp_pop;

	always_comb begin
		priority if (cmd.ins_start) begin
			rd_addr = tail;
		end else if (cmd.ins_shift) begin
			rd_addr = wrap_dec(ptr_q);
		end else if (cmd.exp_read) begin
			rd_addr = head_q;
		end else begin
			rd_addr = wrap_inc(head_q);
		end
	end

	// List memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			list_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= list_q[rd_addr];
		end
	end

	// Input capture, slot targets, current expiry, output payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q  <= mode;
			id_q    <= timer_id;
			dl_q    <= deadline;
			queue_q <= dest_queue;
			byte_q  <= payload;
		end
		if (cmd.ins_start) begin
			target_q[id_q] <= {queue_q, byte_q};
		end
		if (cmd.exp_pop) begin
			cur_q <= rd_q.slot;
		end
		if (cmd.emit) begin
			exp_id_q <= cur_q;
			oq_q     <= target_q[cur_q][Q_W+BYTE_W-1:BYTE_W];
			ob_q     <= target_q[cur_q][BYTE_W-1:0];
			last_q   <= !st.more;
		end
	end

	// Counters, pointers, running bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			next_dl_q   <= NO_DEADLINE;
			cnt_q       <= '0;
			head_q      <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cap && !mode) begin
				tick_q <= tick_q + 1'b1;
			end
			if (cmd.ins_start) begin
				ptr_q           <= tail;
				rem_q           <= cnt_q;
				running_q[id_q] <= 1'b1;
			end
			if (cmd.ins_shift) begin
				ptr_q <= wrap_dec(ptr_q);
				rem_q <= rem_q - 1'b1;
			end
			if (cmd.ins_put) begin
				cnt_q <= cnt_q + 1'b1;
				if (rem_q == '0) begin
					next_dl_q <= dl_q;
				end
			end
			if (cmd.exp_pop) begin
				cnt_q                <= cnt_q - 1'b1;
				head_q               <= wrap_inc(head_q);
				running_q[rd_q.slot] <= 1'b0;
			end
			if (cmd.exp_done) begin
				next_dl_q <= (cnt_q == '0) ? NO_DEADLINE : rd_q.dl;
			end
			// drop the valid on a completed transfer, raise it on a new result
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status to controller
	always_comb begin
		st.is_set   = mode_q;
		st.due      = (next_dl_q <= tick_q);
		st.cnt_zero = (cnt_q == '0);
		st.ins_ok   = !running_q[id_q] && (cnt_q < CW'(MAX_TIMERS));
		st.rem_one  = (rem_q == CW'(1));
		st.shift    = (rd_q.dl > dl_q);
		st.more     = (cnt_q != '0) && (rd_q.dl <= tick_q);
		st.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid    = out_valid_q;
	assign expired_id   = exp_id_q;
	assign out_queue    = oq_q;
	assign out_byte     = ob_q;
	assign last         = last_q;
	assign active_count = cnt_q;
	assign running      = running_q;

endmodule
